// ===== sv/quaternion_to_euler_angles_assert.svh =====
// Assertion helpers shared by the checker
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Property that must hold in the same cycle
`define Q2E_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Property that must hold in the next cycle
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/q2e_pkg.sv =====
`default_nettype none
package q2e_pkg;
	localparam int CORDIC_STEPS = 14;
	localparam int ANGLE_FRAC_BITS = 13;
	localparam int TABLE_LEN = 24;

	localparam int QW = 16;
	localparam int PW = 32;
	localparam int SW = 34;
	localparam int S_W = 32;
	localparam int RW = 62;
	localparam int SQRT_TOP = 60;
	localparam int SQRT_STEPS = 31;
	localparam int SQRT_RES_W = 31;
	localparam int SQ_STEP_W = 5;
	localparam int VW = 46;
	localparam int ZW = 32;
	localparam int NORM_STEPS = 6;
	localparam int NORM_STEP_W = 3;
	localparam int NORM_SH_W = 6;
	localparam int NORM_BIT = 40;
	localparam int STEP_W = 5;
	localparam int OUT_W = 15;
	localparam int OUT_SHIFT = 30 - ANGLE_FRAC_BITS;

	localparam int LANES = 3;
	localparam int LANE_ROLL = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_YAW = 2;

	typedef logic signed [ZW-1:0] angle_t;

	localparam angle_t HALF_PI = 32'sd1686629713;
	localparam logic signed [ZW:0] OUT_HI = (ZW+1)'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [ZW:0] OUT_LO = -OUT_HI - (ZW+1)'(1);

	typedef struct packed {
		logic signed [SW-1:0]  rn;
		logic signed [SW-1:0]  rd;
		logic signed [SW-1:0]  yn;
		logic signed [SW-1:0]  yd;
		logic signed [S_W-1:0] s;
		logic                  clamp;
	} side_t;

	typedef struct packed {
		logic [RW-1:0] v;
		logic [RW-1:0] res;
		side_t         side;
	} root_t;

	typedef struct packed {
		logic signed [VW-1:0] n;
		logic signed [VW-1:0] d;
		angle_t               z;
		logic                 hold;
	} lane_t;

	typedef lane_t [LANES-1:0] lanes_t;

	typedef struct packed {
		lanes_t lane;
		logic   clamp;
	} vec_t;

	function automatic angle_t atan_entry(input logic [STEP_W-1:0] i);
		angle_t a;
		case (i)
			5'd0:    a = 32'sh3243F6A8;
			5'd1:    a = 32'sh1DAC6705;
			5'd2:    a = 32'sh0FADBAFC;
			5'd3:    a = 32'sh07F56EA6;
			5'd4:    a = 32'sh03FEAB76;
			5'd5:    a = 32'sh01FFD55B;
			5'd6:    a = 32'sh00FFFAAA;
			5'd7:    a = 32'sh007FFF55;
			5'd8:    a = 32'sh003FFFEA;
			5'd9:    a = 32'sh001FFFFD;
			5'd10:   a = 32'sh000FFFFF;
			5'd11:   a = 32'sh0007FFFF;
			5'd12:   a = 32'sh0003FFFF;
			5'd13:   a = 32'sh0001FFFF;
			5'd14:   a = 32'sh0000FFFF;
			5'd15:   a = 32'sh00007FFF;
			5'd16:   a = 32'sh00003FFF;
			5'd17:   a = 32'sh00001FFF;
			5'd18:   a = 32'sh00000FFF;
			5'd19:   a = 32'sh000007FF;
			5'd20:   a = 32'sh000003FF;
			5'd21:   a = 32'sh000001FF;
			5'd22:   a = 32'sh000000FF;
			5'd23:   a = 32'sh0000007F;
			default: a = '0;
		endcase
		return a;
	endfunction

	// clamp to +-pi/2, round half up, saturate to the output width
	function automatic logic [OUT_W-1:0] to_out(input angle_t z);
		angle_t zc;
		logic signed [ZW:0] r;
		zc = (z > HALF_PI) ? HALF_PI : ((z < -HALF_PI) ? -HALF_PI : z);
		r = ((ZW+1)'(zc) + ((ZW+1)'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
		if (r > OUT_HI) begin
			r = OUT_HI;
		end else if (r < OUT_LO) begin
			r = OUT_LO;
		end
		return r[OUT_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== sv/q2e_front.sv =====
`default_nettype none
module q2e_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [2:0]                   en,
	input  logic                         vld_in,
	input  logic signed [q2e_pkg::QW-1:0] quat_w,
	input  logic signed [q2e_pkg::QW-1:0] quat_x,
	input  logic signed [q2e_pkg::QW-1:0] quat_y,
	input  logic signed [q2e_pkg::QW-1:0] quat_z,
	output logic [2:0]                   vld,
	output q2e_pkg::root_t               root
);
	import q2e_pkg::*;

	logic [2:0] vld_q;
	logic signed [PW-1:0] pwx_s1, pyz_s1, pxx_s1, pyy_s1, pwz_s1, pxy_s1, pzz_s1, pwy_s1, pzx_s1;
	side_t side_nxt, side_s2;
	root_t root_s3;
	logic signed [SW-1:0] sraw;
	logic signed [SW-1:0] one_q30;
	logic [SQRT_RES_W-1:0] smag;
	logic [RW-1:0] sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= vld_in;
			if (en[1]) vld_q[1] <= vld_q[0];
			if (en[2]) vld_q[2] <= vld_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pwx_s1 <= quat_w * quat_x;
			pyz_s1 <= quat_y * quat_z;
			pxx_s1 <= quat_x * quat_x;
			pyy_s1 <= quat_y * quat_y;
			pwz_s1 <= quat_w * quat_z;
			pxy_s1 <= quat_x * quat_y;
			pzz_s1 <= quat_z * quat_z;
			pwy_s1 <= quat_w * quat_y;
			pzx_s1 <= quat_z * quat_x;
		end
	end

	always_comb begin
		one_q30 = SW'(1) <<< 30;
		side_nxt.rn = (SW'(pwx_s1) + SW'(pyz_s1)) <<< 1;
		side_nxt.rd = one_q30 - ((SW'(pxx_s1) + SW'(pyy_s1)) <<< 1);
		side_nxt.yn = (SW'(pwz_s1) + SW'(pxy_s1)) <<< 1;
		side_nxt.yd = one_q30 - ((SW'(pyy_s1) + SW'(pzz_s1)) <<< 1);
		sraw = (SW'(pwy_s1) - SW'(pzx_s1)) <<< 1;
		// saturate the arcsine argument to unit magnitude
		if (sraw > one_q30) begin
			side_nxt.s = S_W'(one_q30);
			side_nxt.clamp = 1'b1;
		end else if (sraw < -one_q30) begin
			side_nxt.s = S_W'(-one_q30);
			side_nxt.clamp = 1'b1;
		end else begin
			side_nxt.s = S_W'(sraw);
			side_nxt.clamp = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) side_s2 <= side_nxt;
	end

	always_comb begin
		smag = side_s2.s[S_W-1] ? SQRT_RES_W'(-side_s2.s) : SQRT_RES_W'(side_s2.s);
		sq = smag * smag;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			root_s3.v <= (RW'(1) << SQRT_TOP) - sq;
			root_s3.res <= '0;
			root_s3.side <= side_s2;
		end
	end

	assign vld = vld_q;
	assign root = root_s3;
endmodule
`default_nettype wire

// ===== sv/q2e_sqrt_cell.sv =====
`default_nettype none
module q2e_sqrt_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_in,
	input  logic [q2e_pkg::SQ_STEP_W-1:0]   step,
	input  q2e_pkg::root_t                  d_in,
	output logic                            vld,
	output q2e_pkg::root_t                  d_out
);
	import q2e_pkg::*;

	logic vld_q;
	root_t data_q, nxt;
	logic [RW-1:0] rbit, trial;

	// one result bit per cell, restoring square root
	always_comb begin
		nxt = d_in;
		rbit = RW'(1) << (7'(SQRT_TOP) - {1'b0, step, 1'b0});
		trial = d_in.res + rbit;
		if (d_in.v >= trial) begin
			nxt.v = d_in.v - trial;
			nxt.res = (d_in.res >> 1) + rbit;
		end else begin
			nxt.res = d_in.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) data_q <= nxt;
	end

	assign vld = vld_q;
	assign d_out = data_q;
endmodule
`default_nettype wire

// ===== sv/q2e_norm_cell.sv =====
`default_nettype none
module q2e_norm_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             vld_in,
	input  logic [q2e_pkg::NORM_STEP_W-1:0]  step,
	input  q2e_pkg::vec_t                    d_in,
	output logic                             vld,
	output q2e_pkg::vec_t                    d_out
);
	import q2e_pkg::*;

	logic vld_q;
	vec_t data_q, nxt;
	logic [NORM_SH_W-1:0] sh;
	logic [VW-1:0] lim;
	logic [VW-1:0] an [LANES];
	logic [VW-1:0] ad [LANES];
	logic [VW-1:0] m [LANES];

	// binary leading-zero shift: 32, 16, 8, 4, 2, 1 toward 2^40
	always_comb begin
		nxt = d_in;
		sh = NORM_SH_W'(1) << (NORM_STEP_W'(NORM_STEPS - 1) - step);
		lim = VW'(1) << (7'(NORM_BIT + 1) - {1'b0, sh});
		for (int k = 0; k < LANES; k++) begin
			an[k] = d_in.lane[k].n[VW-1] ? VW'(-d_in.lane[k].n) : VW'(d_in.lane[k].n);
			ad[k] = d_in.lane[k].d[VW-1] ? VW'(-d_in.lane[k].d) : VW'(d_in.lane[k].d);
			m[k] = (an[k] > ad[k]) ? an[k] : ad[k];
			if (m[k] < lim) begin
				nxt.lane[k].n = d_in.lane[k].n <<< sh;
				nxt.lane[k].d = d_in.lane[k].d <<< sh;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) data_q <= nxt;
	end

	assign vld = vld_q;
	assign d_out = data_q;
endmodule
`default_nettype wire

// ===== sv/q2e_cordic_cell.sv =====
`default_nettype none
module q2e_cordic_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_in,
	input  logic [q2e_pkg::STEP_W-1:0]  step,
	input  q2e_pkg::vec_t               d_in,
	output logic                        vld,
	output q2e_pkg::vec_t               d_out
);
	import q2e_pkg::*;

	logic vld_q;
	vec_t data_q, nxt;
	angle_t a;
	logic signed [VW-1:0] xs [LANES];
	logic signed [VW-1:0] ys [LANES];

	// vectoring rotation: drive n toward zero, accumulate angle
	always_comb begin
		nxt = d_in;
		a = atan_entry(step);
		for (int k = 0; k < LANES; k++) begin
			xs[k] = d_in.lane[k].d >>> step;
			ys[k] = d_in.lane[k].n >>> step;
			if (!d_in.lane[k].hold) begin
				if (!d_in.lane[k].n[VW-1]) begin
					nxt.lane[k].d = d_in.lane[k].d + ys[k];
					nxt.lane[k].n = d_in.lane[k].n - xs[k];
					nxt.lane[k].z = d_in.lane[k].z + a;
				end else begin
					nxt.lane[k].d = d_in.lane[k].d - ys[k];
					nxt.lane[k].n = d_in.lane[k].n + xs[k];
					nxt.lane[k].z = d_in.lane[k].z - a;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) data_q <= nxt;
	end

	assign vld = vld_q;
	assign d_out = data_q;
endmodule
`default_nettype wire

// ===== sv/quaternion_to_euler_angles.sv =====
// Pipeline stages from request to result: 3 front, 31 square root, 1 setup,
// 6 normalize, 14 CORDIC, 1 output; the one-bit-per-cell square root chain is the longest.
// Throughput: one request per cycle; each stage holds only while the stage after it is
// full and stalled, so empty stages keep filling behind a waiting result.
// Reset: arst_n clears every stage valid bit at once; payload registers are not reset.
`default_nettype none
module quaternion_to_euler_angles (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic signed [q2e_pkg::QW-1:0]       quat_w,
	input  logic signed [q2e_pkg::QW-1:0]       quat_x,
	input  logic signed [q2e_pkg::QW-1:0]       quat_y,
	input  logic signed [q2e_pkg::QW-1:0]       quat_z,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic signed [q2e_pkg::OUT_W-1:0]    roll_angle,
	output logic signed [q2e_pkg::OUT_W-1:0]    pitch_angle,
	output logic signed [q2e_pkg::OUT_W-1:0]    yaw_angle,
	output logic                                pitch_clamped
);
	import q2e_pkg::*;

	localparam int SQ_BASE = 3;
	localparam int PREP_IDX = SQ_BASE + SQRT_STEPS;
	localparam int NORM_BASE = PREP_IDX + 1;
	localparam int CORD_BASE = NORM_BASE + NORM_STEPS;
	localparam int OUT_IDX = CORD_BASE + CORDIC_STEPS;
	localparam int NSTG = OUT_IDX + 1;

	wire [NSTG-1:0] vld;
	wire [NSTG:0] en;

	root_t rt [SQRT_STEPS+1];
	vec_t nv [NORM_STEPS+1];
	vec_t cv [CORDIC_STEPS+1];

	logic prep_vld_q, out_vld_q;
	vec_t prep_q, prep_nxt;
	root_t src;
	logic signed [VW-1:0] pn [LANES];
	logic signed [VW-1:0] pd [LANES];
	logic [OUT_W-1:0] roll_q, pitch_q, yaw_q;
	logic clamp_q;

	// a stage loads when it is empty or the stage after it moves
	genvar g;
	generate
		for (g = 0; g < NSTG; g++) begin : g_en
			assign en[g] = !vld[g] || en[g+1];
		end
	endgenerate
	assign en[NSTG] = rsp_ready;
	assign req_ready = en[0];

	q2e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en[2:0]),
		.vld_in (req_valid),
		.quat_w (quat_w),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.vld    (vld[2:0]),
		.root   (rt[0])
	);

	generate
		for (g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
			q2e_sqrt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en[SQ_BASE+g]),
				.vld_in (vld[SQ_BASE+g-1]),
				.step   (SQ_STEP_W'(g)),
				.d_in   (rt[g]),
				.vld    (vld[SQ_BASE+g]),
				.d_out  (rt[g+1])
			);
		end
	endgenerate

	// set up the three ratios: zero denominator gives a fixed angle, else make d positive
	always_comb begin
		src = rt[SQRT_STEPS];
		prep_nxt.clamp = src.side.clamp;
		pn[LANE_ROLL] = VW'(src.side.rn);
		pd[LANE_ROLL] = VW'(src.side.rd);
		pn[LANE_PITCH] = VW'(src.side.s);
		pd[LANE_PITCH] = VW'($signed({1'b0, src.res[SQRT_RES_W-1:0]}));
		pn[LANE_YAW] = VW'(src.side.yn);
		pd[LANE_YAW] = VW'(src.side.yd);
		for (int k = 0; k < LANES; k++) begin
			prep_nxt.lane[k].hold = (pd[k] == '0);
			if (pd[k] == '0) begin
				prep_nxt.lane[k].z = (pn[k] > 0) ? HALF_PI : ((pn[k] < 0) ? -HALF_PI : '0);
			end else begin
				prep_nxt.lane[k].z = '0;
			end
			prep_nxt.lane[k].n = pd[k][VW-1] ? -pn[k] : pn[k];
			prep_nxt.lane[k].d = pd[k][VW-1] ? -pd[k] : pd[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en[PREP_IDX]) prep_vld_q <= vld[PREP_IDX-1];
			if (en[OUT_IDX]) out_vld_q <= vld[OUT_IDX-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[PREP_IDX]) prep_q <= prep_nxt;
	end

	assign vld[PREP_IDX] = prep_vld_q;
	assign nv[0] = prep_q;

	generate
		for (g = 0; g < NORM_STEPS; g++) begin : g_norm
			q2e_norm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en[NORM_BASE+g]),
				.vld_in (vld[NORM_BASE+g-1]),
				.step   (NORM_STEP_W'(g)),
				.d_in   (nv[g]),
				.vld    (vld[NORM_BASE+g]),
				.d_out  (nv[g+1])
			);
		end
	endgenerate

	assign cv[0] = nv[NORM_STEPS];

	generate
		for (g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
			q2e_cordic_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en[CORD_BASE+g]),
				.vld_in (vld[CORD_BASE+g-1]),
				.step   (STEP_W'(g)),
				.d_in   (cv[g]),
				.vld    (vld[CORD_BASE+g]),
				.d_out  (cv[g+1])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en[OUT_IDX]) begin
			roll_q <= to_out(cv[CORDIC_STEPS].lane[LANE_ROLL].z);
			pitch_q <= to_out(cv[CORDIC_STEPS].lane[LANE_PITCH].z);
			yaw_q <= to_out(cv[CORDIC_STEPS].lane[LANE_YAW].z);
			clamp_q <= cv[CORDIC_STEPS].clamp;
		end
	end

	assign vld[OUT_IDX] = out_vld_q;
	assign rsp_valid = out_vld_q;
	assign roll_angle = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle = yaw_q;
	assign pitch_clamped = clamp_q;
endmodule
`default_nettype wire

// ===== sv/q2e_checker.sv =====
`default_nettype none
`include "quaternion_to_euler_angles_assert.svh"
module q2e_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [q2e_pkg::OUT_W-1:0]        roll_angle,
	input logic [q2e_pkg::OUT_W-1:0]        pitch_angle,
	input logic [q2e_pkg::OUT_W-1:0]        yaw_angle,
	input logic                             pitch_clamped
);
	import q2e_pkg::*;

	localparam logic [OUT_W-1:0] PITCH_POS = to_out(HALF_PI);
	localparam logic [OUT_W-1:0] PITCH_NEG = to_out(-HALF_PI);

	// a stalled result keeps its values
	`Q2E_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(roll_angle) && $stable(pitch_angle) && $stable(yaw_angle) && $stable(pitch_clamped), "result changed while stalled")

	// an empty or draining output lets a request in
	`Q2E_ASSERT_NOW(a_req_open, !rsp_valid || rsp_ready, req_ready, "request blocked with output free")

	// a saturated arcsine argument gives pitch of plus or minus pi/2
	`Q2E_ASSERT_NOW(a_pitch_sat, rsp_valid && pitch_clamped, pitch_angle == PITCH_POS || pitch_angle == PITCH_NEG, "clamped pitch not at pi/2")
endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);
`default_nettype wire

// ===== test/quaternion_to_euler_angles_tb.sv =====
`default_nettype none
module quaternion_to_euler_angles_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import q2e_pkg::*;

	typedef struct packed {
		logic signed [OUT_W-1:0] roll;
		logic signed [OUT_W-1:0] pitch;
		logic signed [OUT_W-1:0] yaw;
		logic                    clamped;
	} euler_t;

	int mismatches = 0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	localparam longint UNIT_Q30 = 64'sd1 << 30;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	function automatic longint atan_step_angle(input int i);
		longint t[24] = '{
			'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
			'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
			'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
			'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
		return t[i];
	endfunction

	function automatic longint magnitude(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint floor_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// CORDIC arctangent of n/d in Q.30, within +-pi/2
	function automatic longint atan_of_ratio(input longint n, input longint d);
		longint cx, cy, ang, sx, sy;
		ang = 0;
		if (d == 0) return n > 0 ? HALF_PI_Q30 : (n < 0 ? -HALF_PI_Q30 : 0);
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		while ((magnitude(n) > magnitude(d) ? magnitude(n) : magnitude(d)) < (64'sd1 << 40)) begin
			n *= 2;
			d *= 2;
		end
		cx = d;
		cy = n;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			sx = cx >>> i;
			sy = cy >>> i;
			if (cy >= 0) begin
				cx += sy;
				cy -= sx;
				ang += atan_step_angle(i);
			end else begin
				cx -= sy;
				cy += sx;
				ang -= atan_step_angle(i);
			end
		end
		if (ang > HALF_PI_Q30) ang = HALF_PI_Q30;
		if (ang < -HALF_PI_Q30) ang = -HALF_PI_Q30;
		return ang;
	endfunction

	function automatic logic [OUT_W-1:0] angle_to_port(input longint ang);
		longint r;
		r = (ang + (64'sd1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
		if (r > 16383) r = 16383;
		if (r < -16384) r = -16384;
		return r[OUT_W-1:0];
	endfunction

	function automatic euler_t quat_to_euler(input logic signed [15:0] qw, qx, qy, qz);
		longint w, x, y, z, rn, rd, yn, yd, s, c;
		euler_t e;
		w = qw; x = qx; y = qy; z = qz;
		rn = 2 * (w * x + y * z);
		rd = UNIT_Q30 - 2 * (x * x + y * y);
		yn = 2 * (w * z + x * y);
		yd = UNIT_Q30 - 2 * (y * y + z * z);
		s = 2 * (w * y - z * x);
		e.clamped = 1'b0;
		if (s > UNIT_Q30) begin
			s = UNIT_Q30;
			e.clamped = 1'b1;
		end else if (s < -UNIT_Q30) begin
			s = -UNIT_Q30;
			e.clamped = 1'b1;
		end
		c = floor_sqrt((64'd1 << 60) - s * s);
		e.roll = angle_to_port(atan_of_ratio(rn, rd));
		e.pitch = angle_to_port(atan_of_ratio(s, c));
		e.yaw = angle_to_port(atan_of_ratio(yn, yd));
		return e;
	endfunction

	class euler_scoreboard;
		euler_t pending[$];

		function void note_request(logic signed [15:0] qw, qx, qy, qz);
			pending.push_back(quat_to_euler(qw, qx, qy, qz));
		endfunction

		task check_result(euler_t got);
			euler_t want;
			if (pending.size() == 0) begin
				report("unexpected result", 0, 0);
				return;
			end
			want = pending.pop_front();
			if (got.roll !== want.roll) report("roll", got.roll, want.roll);
			if (got.pitch !== want.pitch) report("pitch", got.pitch, want.pitch);
			if (got.yaw !== want.yaw) report("yaw", got.yaw, want.yaw);
			if (got.clamped !== want.clamped) report("clamp", got.clamped, want.clamped);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0, pitch_clamped;
	logic signed [15:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
	logic signed [OUT_W-1:0] roll_angle, pitch_angle, yaw_angle;
	bit requests_done = 0, hold_rsp = 0;
	euler_scoreboard board = new();

	always #5 clk = ~clk;

	quaternion_to_euler_angles dut (.*);

	// called at a falling edge; returns at the falling edge after the accept
	task automatic send_quat(input logic signed [15:0] qw, qx, qy, qz, input bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1;
		quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
		do @(posedge clk); while (!req_ready);
		board.note_request(qw, qx, qy, qz);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_comp();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return $urandom_range(0, 1) ? 16'sh5A82 : -16'sh5A82;
			default: return 16'($urandom);
		endcase
	endfunction

	// random unit-ish quaternion: scale a random vector toward norm 1
	task automatic send_unit(input bit no_gap = 0);
		real a[4], n;
		logic signed [15:0] q[4];
		n = 0;
		foreach (a[i]) begin
			a[i] = $itor($signed($urandom_range(0, 65535)) - 32768);
			n += a[i] * a[i];
		end
		n = $sqrt(n);
		if (n == 0) n = 1;
		foreach (q[i]) q[i] = 16'($rtoi(a[i] / n * 32767.0));
		send_quat(q[0], q[1], q[2], q[3], no_gap);
	endtask

	initial begin
		logic signed [15:0] edge_vals[4] = '{16'sh7FFF, 16'sh8000, 0, 16'sh4000};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// identity, axis rotations, zero quaternion, extremes
		send_quat(16'sh7FFF, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(16'sh5A82, 16'sh5A82, 0, 0);
		send_quat(16'sh5A82, 0, 16'sh5A82, 0);
		send_quat(16'sh5A82, 0, -16'sh5A82, 0);
		send_quat(16'sh5A82, 0, 0, 16'sh5A82);
		send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_quat(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
		send_quat(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
		send_quat(0, 16'sh5A82, 0, 0);
		send_quat(0, 0, 16'sh7FFF, 0);
		send_quat(16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000);
		send_quat(16'sh4000, -16'sh4000, 16'sh4000, 16'sh4000);
		send_quat(-1, -1, -1, -1);
		send_quat(1, 1, 1, 1);
		foreach (edge_vals[i]) send_quat(edge_vals[i], edge_vals[3-i], edge_vals[i], edge_vals[(i+1)%4]);
		// block fills up while the receiver holds off
		hold_rsp = 1;
		for (int i = 0; i < 90; i++) send_unit(1);
		// drain fully before going on
		req_valid <= 0;
		wait (board.pending.size() == 0);
		@(negedge clk);
		for (int i = 0; i < 660; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_quat(pick_comp(), pick_comp(), pick_comp(), pick_comp(), i % 200 < 30);
			else
				send_unit(i % 200 < 30);
		end
		req_valid <= 0;
		requests_done = 1;
	end

	initial begin
		@(posedge arst_n);
		wait (hold_rsp);
		repeat (200) @(posedge clk);
		hold_rsp = 0;
	end

	// receiver: random idle before each result, hold off while asked to
	initial begin
		int idle;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			idle = $urandom_range(0, 4);
			if (idle > 0 || hold_rsp) begin
				rsp_ready <= 0;
				repeat (idle) @(negedge clk);
				while (hold_rsp) @(negedge clk);
			end
			rsp_ready <= 1;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			board.check_result('{roll_angle, pitch_angle, yaw_angle, pitch_clamped});
	end

	initial begin
		wait (requests_done);
		wait (board.pending.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("quaternion_to_euler_angles_tb passed");
		else
			$display("quaternion_to_euler_angles_tb failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("quaternion_to_euler_angles_tb failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/q2e_pkg.sv
sv/q2e_front.sv
sv/q2e_sqrt_cell.sv
sv/q2e_norm_cell.sv
sv/q2e_cordic_cell.sv
sv/quaternion_to_euler_angles.sv
sv/q2e_checker.sv
test/quaternion_to_euler_angles_tb.sv
